@@ rtl/core/tgr_pkg.sv @@
package tgr_pkg;

    localparam int COORD_W = 13;
    localparam int DIM_W   = 12;
    localparam int TIME_W  = 48;
    localparam int LP_W    = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int DELTA_W = COORD_W + 1;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 12'd1072;
    localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 12'd1448;
    localparam logic [DIM_W-1:0] RST_STRIP_HEIGHT  = 12'd80;
    localparam logic [DIM_W-1:0] RST_TAP_SLOP      = 12'd20;
    localparam logic [DIM_W-1:0] RST_SWIPE_DIST    = 12'd80;
    localparam logic [LP_W-1:0]  RST_LONG_PRESS    = 24'd500000;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_PAGE_BACK = 4'd1,
        ACT_PAGE_FWD  = 4'd2,
        ACT_BACK      = 4'd3,
        ACT_CONFIRM   = 4'd4,
        ACT_UI_ITEM   = 4'd5,
        ACT_LEFT      = 4'd6,
        ACT_RIGHT     = 4'd7,
        ACT_UP        = 4'd8,
        ACT_DOWN      = 4'd9
    } action_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_STRIP_HEIGHT  = 3'd2,
        REG_TAP_SLOP      = 3'd3,
        REG_SWIPE_DIST    = 3'd4,
        REG_LONG_PRESS    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] screen_width;
        logic [DIM_W-1:0] screen_height;
        logic [DIM_W-1:0] tap_slop;
        logic [DIM_W-1:0] swipe_distance;
        logic [LP_W-1:0]  long_press_us;
        logic [DIM_W-1:0] half_width;
        logic [DIM_W-1:0] left_col;
        logic [DIM_W-1:0] right_col;
        logic [DIM_W-1:0] strip_top;
        logic             zone_ok;
    } cfg_t;

    typedef struct packed {
        logic                      touch_down;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [TIME_W-1:0]         time_us;
        logic                      reader_mode;
    } item_t;

    typedef struct packed {
        action_t                   action;
        logic                      press;
        logic                      release_res;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
    } res_t;

    // floor(v/10) by reciprocal, exact for v below 2^15
    function automatic logic [DIM_W-1:0] div10(input logic [14:0] v);
        logic [31:0] p;
        p = 32'(v) * 32'd52429;
        return p[30:19];
    endfunction

    function automatic logic [DIM_W-1:0] width_frac(input logic [DIM_W-1:0] w,
                                                     input logic [2:0] tenths);
        logic [14:0] m;
        m = 15'(w) * 15'(tenths);
        return div10(m);
    endfunction

endpackage

@@ rtl/core/tgr_cfg.sv @@
module tgr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [tgr_pkg::IDX_W-1:0]   cfg_wr_index,
    input  logic [tgr_pkg::CFG_W-1:0]   cfg_wr_data,
    output tgr_pkg::cfg_t               cfg
);
    import tgr_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [DIM_W-1:0] strip_reg, strip_next;
    logic [DIM_W-1:0] slop_reg, slop_next;
    logic [DIM_W-1:0] swipe_reg, swipe_next;
    logic [LP_W-1:0]  long_press_reg, long_press_next;

    // zone boundaries, loaded together with the registers above
    logic [DIM_W-1:0] half_reg, left_col_reg, right_col_reg, strip_top_reg;
    logic             zone_ok_reg;

    always_comb begin
        width_next      = width_reg;
        height_next     = height_reg;
        strip_next      = strip_reg;
        slop_next       = slop_reg;
        swipe_next      = swipe_reg;
        long_press_next = long_press_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_SCREEN_WIDTH:  width_next      = cfg_wr_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_next     = cfg_wr_data[DIM_W-1:0];
                REG_STRIP_HEIGHT:  strip_next      = cfg_wr_data[DIM_W-1:0];
                REG_TAP_SLOP:      slop_next       = cfg_wr_data[DIM_W-1:0];
                REG_SWIPE_DIST:    swipe_next      = cfg_wr_data[DIM_W-1:0];
                REG_LONG_PRESS:    long_press_next = cfg_wr_data[LP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= RST_SCREEN_WIDTH;
            height_reg     <= RST_SCREEN_HEIGHT;
            strip_reg      <= RST_STRIP_HEIGHT;
            slop_reg       <= RST_TAP_SLOP;
            swipe_reg      <= RST_SWIPE_DIST;
            long_press_reg <= RST_LONG_PRESS;
            half_reg       <= RST_SCREEN_WIDTH >> 1;
            left_col_reg   <= width_frac(RST_SCREEN_WIDTH, 3'd3);
            right_col_reg  <= width_frac(RST_SCREEN_WIDTH, 3'd7);
            strip_top_reg  <= RST_SCREEN_HEIGHT - RST_STRIP_HEIGHT;
            zone_ok_reg    <= 1'b1;
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            strip_reg      <= strip_next;
            slop_reg       <= slop_next;
            swipe_reg      <= swipe_next;
            long_press_reg <= long_press_next;
            half_reg       <= width_next >> 1;
            left_col_reg   <= width_frac(width_next, 3'd3);
            right_col_reg  <= width_frac(width_next, 3'd7);
            strip_top_reg  <= height_next - strip_next;
            zone_ok_reg    <= (width_next != '0) && (height_next > strip_next);
        end
    end

    always_comb begin
        cfg.screen_width   = width_reg;
        cfg.screen_height  = height_reg;
        cfg.tap_slop       = slop_reg;
        cfg.swipe_distance = swipe_reg;
        cfg.long_press_us  = long_press_reg;
        cfg.half_width     = half_reg;
        cfg.left_col       = left_col_reg;
        cfg.right_col      = right_col_reg;
        cfg.strip_top      = strip_top_reg;
        cfg.zone_ok        = zone_ok_reg;
    end

endmodule

@@ rtl/core/tgr_zone.sv @@
module tgr_zone (
    input  tgr_pkg::cfg_t                        cfg,
    input  logic signed [tgr_pkg::COORD_W-1:0]   begin_x,
    input  logic signed [tgr_pkg::COORD_W-1:0]   begin_y,
    input  logic                                 reader_mode,
    output tgr_pkg::action_t                     zone
);
    import tgr_pkg::*;

    logic [DIM_W-1:0] xu;
    logic [DIM_W-1:0] yu;
    logic             off_screen;

    assign xu = begin_x[DIM_W-1:0];
    assign yu = begin_y[DIM_W-1:0];
    assign off_screen = begin_x[COORD_W-1] || begin_y[COORD_W-1] ||
                        (xu >= cfg.screen_width) || (yu >= cfg.screen_height);

    always_comb begin
        if (!cfg.zone_ok || off_screen) begin
            zone = ACT_NONE;
        end else if (yu >= cfg.strip_top) begin
            if (reader_mode) begin
                zone = (xu < cfg.half_width) ? ACT_PAGE_BACK : ACT_PAGE_FWD;
            end else begin
                zone = (xu < cfg.half_width) ? ACT_BACK : ACT_CONFIRM;
            end
        end else if (!reader_mode) begin
            zone = ACT_UI_ITEM;
        end else if (xu < cfg.left_col) begin
            zone = ACT_PAGE_BACK;
        end else if (xu >= cfg.right_col) begin
            zone = ACT_PAGE_FWD;
        end else begin
            zone = ACT_CONFIRM;
        end
    end

endmodule

@@ rtl/core/tgr_engine.sv @@
module tgr_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  tgr_pkg::cfg_t     cfg,
    input  logic              in_valid,
    input  tgr_pkg::item_t    in_item,
    output logic              in_take,
    output logic              m_valid,
    input  logic              m_ready,
    output tgr_pkg::res_t     m_res
);
    import tgr_pkg::*;

    logic                      active_reg, active_next;
    logic                      hold_fired_reg, hold_fired_next;
    logic signed [COORD_W-1:0] begin_x_reg, begin_x_next;
    logic signed [COORD_W-1:0] begin_y_reg, begin_y_next;
    logic [TIME_W-1:0]         begin_time_reg, begin_time_next;
    action_t                   held_code_reg, held_code_next;

    logic                      out_valid_reg, out_valid_next;
    res_t                      res_reg, res_next;

    logic                      load;
    action_t                   zone;
    logic signed [DELTA_W-1:0] dx, dy;
    logic [COORD_W-1:0]        adx, ady;
    logic                      in_slop;
    logic [TIME_W:0]           elapsed;
    logic                      long_ok;
    action_t                   act;
    logic                      pr, rl;

    tgr_zone u_zone (
        .cfg         (cfg),
        .begin_x     (begin_x_reg),
        .begin_y     (begin_y_reg),
        .reader_mode (in_item.reader_mode),
        .zone        (zone)
    );

    assign in_take = !out_valid_reg || m_ready;
    assign load    = in_valid && in_take;

    always_comb begin
        dx  = DELTA_W'(in_item.pos_x) - DELTA_W'(begin_x_reg);
        dy  = DELTA_W'(in_item.pos_y) - DELTA_W'(begin_y_reg);
        adx = dx[DELTA_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
        ady = dy[DELTA_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
        in_slop = (adx <= COORD_W'(cfg.tap_slop)) && (ady <= COORD_W'(cfg.tap_slop));
        // borrow out of the top marks time running backwards
        elapsed = {1'b0, in_item.time_us} - {1'b0, begin_time_reg};
        long_ok = !elapsed[TIME_W] &&
                  (elapsed[TIME_W-1:0] >= TIME_W'(cfg.long_press_us));
    end

    always_comb begin
        active_next     = active_reg;
        hold_fired_next = hold_fired_reg;
        begin_x_next    = begin_x_reg;
        begin_y_next    = begin_y_reg;
        begin_time_next = begin_time_reg;
        held_code_next  = held_code_reg;
        act = ACT_NONE;
        pr  = 1'b0;
        rl  = 1'b0;

        if (in_item.touch_down && !active_reg) begin
            active_next     = 1'b1;
            hold_fired_next = 1'b0;
            begin_x_next    = in_item.pos_x;
            begin_y_next    = in_item.pos_y;
            begin_time_next = in_item.time_us;
            held_code_next  = ACT_NONE;
        end else if (active_reg) begin
            if (in_item.touch_down) begin
                if (!hold_fired_reg && in_slop && long_ok) begin
                    held_code_next = zone;
                    if (zone != ACT_NONE) begin
                        hold_fired_next = 1'b1;
                        act = zone;
                        pr  = 1'b1;
                    end
                end
            end else begin
                if (hold_fired_reg) begin
                    act = held_code_reg;
                    rl  = 1'b1;
                end else if (in_slop) begin
                    act = zone;
                    pr  = 1'b1;
                    rl  = 1'b1;
                end else if ((adx >= COORD_W'(cfg.swipe_distance)) && (adx > ady)) begin
                    if (in_item.reader_mode) begin
                        act = dx[DELTA_W-1] ? ACT_PAGE_FWD : ACT_PAGE_BACK;
                    end else begin
                        act = dx[DELTA_W-1] ? ACT_RIGHT : ACT_LEFT;
                    end
                    pr = 1'b1;
                    rl = 1'b1;
                end else if (!in_item.reader_mode &&
                             (ady >= COORD_W'(cfg.swipe_distance))) begin
                    act = dy[DELTA_W-1] ? ACT_DOWN : ACT_UP;
                    pr  = 1'b1;
                    rl  = 1'b1;
                end
                // end the gesture
                active_next     = 1'b0;
                hold_fired_next = 1'b0;
                begin_time_next = '0;
                held_code_next  = ACT_NONE;
            end
        end

        res_next = '0;
        if (act != ACT_NONE) begin
            res_next.action      = act;
            res_next.press       = pr;
            res_next.release_res = rl;
            res_next.origin_x    = begin_x_reg;
            res_next.origin_y    = begin_y_reg;
        end

        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            hold_fired_reg <= 1'b0;
            begin_x_reg    <= '0;
            begin_y_reg    <= '0;
            begin_time_reg <= '0;
            held_code_reg  <= ACT_NONE;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (load) begin
                active_reg     <= active_next;
                hold_fired_reg <= hold_fired_next;
                begin_x_reg    <= begin_x_next;
                begin_y_reg    <= begin_y_next;
                begin_time_reg <= begin_time_next;
                held_code_reg  <= held_code_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = res_reg;

    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (res_reg.action == ACT_NONE)) |-> (res_reg == '0))
        else $error("empty dispatch carries nonzero fields");

    a_hold_needs_gesture: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_fired_reg |-> active_reg)
        else $error("long press held without an active gesture");

    a_held_code_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_code_reg != ACT_NONE) |-> hold_fired_reg)
        else $error("held action stored but long press not fired");

    a_press_starts_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res_next.press && !res_next.release_res) |=> hold_fired_reg)
        else $error("lone press without long press state");

    a_release_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res_next.release_res) |=> !active_reg)
        else $error("gesture still active after a release");

endmodule

@@ rtl/core/touch_gesture_recognizer_top.sv @@
// Touch gesture recognizer: tap, long press and swipe from a stream of touch frames.
//
// Input channel (s_*): one touch frame per transfer. s_tdata carries touch_down,
// pos_x, pos_y and time_us; s_tuser carries reader_mode. Result channel (m_*): one
// dispatch per frame, in frame order: action, press, release_res, origin_x,
// origin_y. An empty dispatch is all zeros.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_wr_index at the
// clock edge (0 width, 1 height, 2 bottom strip, 3 tap slop, 4 swipe distance,
// 5 long press time). Write only while no frame is in flight.
// Path: a frame accepted into the input register moves on to the result register,
// which drives m_tvalid. Throughput: one frame per cycle while m_tready is high;
// the gesture state updates in the same cycle the result register loads.
// Stall: while m_tready is low the result register holds and the input register
// fills, so s_tready drops only once both are occupied.
// Reset (aresetn low, synchronous): registers return to their defaults, the
// gesture ends and both register stages empty.
module touch_gesture_recognizer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // touch_down[0], pos_x[13:1], pos_y[26:14], time_us[74:27], zero fill
    input  logic [tgr_pkg::S_TDATA_W-1:0]     s_tdata,
    // reader_mode[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // action[3:0], press[4], release_res[5], origin_x[18:6], origin_y[31:19]
    output logic [tgr_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tgr_pkg::IDX_W-1:0]         cfg_wr_index,
    input  logic [tgr_pkg::CFG_W-1:0]         cfg_wr_data
);
    import tgr_pkg::*;

    cfg_t  cfg;
    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    item_t s_item;
    logic  in_take;
    logic  s_xfer;
    res_t  m_res;

    assign s_item.touch_down  = s_tdata[0];
    assign s_item.pos_x       = s_tdata[13:1];
    assign s_item.pos_y       = s_tdata[26:14];
    assign s_item.time_us     = s_tdata[74:27];
    assign s_item.reader_mode = s_tuser;

    assign s_tready = !in_valid_reg || in_take;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= s_item;
        end
    end

    tgr_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    tgr_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (in_valid_reg),
        .in_item  (in_item_reg),
        .in_take  (in_take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {m_res.origin_y, m_res.origin_x, m_res.release_res,
                      m_res.press, m_res.action};

endmodule

@@ tb/sv/tgr_dispatch_checker.sv @@
module tgr_dispatch_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // touch_down[0], pos_x[13:1], pos_y[26:14], time_us[74:27], zero fill
    input  logic [tgr_pkg::S_TDATA_W-1:0] s_tdata,
    // reader_mode[0]
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // action[3:0], press[4], release_res[5], origin_x[18:6], origin_y[31:19]
    input  logic [tgr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [tgr_pkg::IDX_W-1:0]     cfg_wr_index,
    input  logic [tgr_pkg::CFG_W-1:0]     cfg_wr_data,
    output int                            mismatches,
    output int                            dispatches_due,
    output int                            dispatches_checked,
    output int                            actions_checked
);
    import tgr_pkg::*;

    logic [DIM_W-1:0]          width_q;
    logic [DIM_W-1:0]          height_q;
    logic [DIM_W-1:0]          strip_q;
    logic [DIM_W-1:0]          slop_q;
    logic [DIM_W-1:0]          swipe_q;
    logic [LP_W-1:0]           hold_us_q;

    logic                      gesture_on;
    logic                      hold_done;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic [TIME_W-1:0]         start_time;
    action_t                   held_action;

    res_t                      due_dispatches[$];

    function automatic action_t zone_of(input int x, input int y, input logic rdr);
        int w;
        int h;
        int b;
        w = int'(width_q);
        h = int'(height_q);
        b = int'(strip_q);
        if (w <= 0 || h <= b || x < 0 || y < 0 || x >= w || y >= h) begin
            return ACT_NONE;
        end
        if (y >= h - b) begin
            if (x < w / 2) begin
                return rdr ? ACT_PAGE_BACK : ACT_BACK;
            end
            return rdr ? ACT_PAGE_FWD : ACT_CONFIRM;
        end
        if (!rdr) begin
            return ACT_UI_ITEM;
        end
        if (x < w * 3 / 10) begin
            return ACT_PAGE_BACK;
        end
        if (x >= w * 7 / 10) begin
            return ACT_PAGE_FWD;
        end
        return ACT_CONFIRM;
    endfunction

    // an empty dispatch carries no origin either
    function automatic res_t make_dispatch(input action_t act, input logic pr, input logic rl);
        res_t r;
        r = '0;
        if (act != ACT_NONE) begin
            r.action      = act;
            r.press       = pr;
            r.release_res = rl;
            r.origin_x    = start_x;
            r.origin_y    = start_y;
        end
        return r;
    endfunction

    task automatic predict_dispatch(input logic [S_TDATA_W-1:0] d, input logic rdr);
        logic              down;
        logic [TIME_W-1:0] t;
        int                x;
        int                y;
        int                dx;
        int                dy;
        int                adx;
        int                ady;
        logic              near;
        action_t           act;
        logic              pr;
        down = d[0];
        x    = int'($signed(d[13:1]));
        y    = int'($signed(d[26:14]));
        t    = d[74:27];
        if (down && !gesture_on) begin
            gesture_on  = 1'b1;
            hold_done   = 1'b0;
            start_x     = d[13:1];
            start_y     = d[26:14];
            start_time  = t;
            held_action = ACT_NONE;
            due_dispatches.push_back(make_dispatch(ACT_NONE, 1'b0, 1'b0));
        end else if (!gesture_on) begin
            due_dispatches.push_back(make_dispatch(ACT_NONE, 1'b0, 1'b0));
        end else begin
            dx   = x - int'(start_x);
            dy   = y - int'(start_y);
            adx  = (dx < 0) ? -dx : dx;
            ady  = (dy < 0) ? -dy : dy;
            near = (adx <= int'(slop_q)) && (ady <= int'(slop_q));
            act  = ACT_NONE;
            if (down) begin
                if (!hold_done && near && t >= start_time &&
                    (t - start_time) >= {24'd0, hold_us_q}) begin
                    held_action = zone_of(int'(start_x), int'(start_y), rdr);
                    if (held_action != ACT_NONE) begin
                        hold_done = 1'b1;
                        act       = held_action;
                    end
                end
                due_dispatches.push_back(make_dispatch(act, 1'b1, 1'b0));
            end else begin
                pr = 1'b1;
                if (hold_done) begin
                    act = held_action;
                    pr  = 1'b0;
                end else if (near) begin
                    act = zone_of(int'(start_x), int'(start_y), rdr);
                end else if (adx >= int'(swipe_q) && adx > ady) begin
                    if (rdr) begin
                        act = (dx < 0) ? ACT_PAGE_FWD : ACT_PAGE_BACK;
                    end else begin
                        act = (dx < 0) ? ACT_RIGHT : ACT_LEFT;
                    end
                end else if (!rdr && ady >= int'(swipe_q)) begin
                    act = (dy < 0) ? ACT_DOWN : ACT_UP;
                end
                due_dispatches.push_back(make_dispatch(act, pr, 1'b1));
                gesture_on  = 1'b0;
                hold_done   = 1'b0;
                start_time  = '0;
                held_action = ACT_NONE;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        if (!aresetn) begin
            width_q            = RST_SCREEN_WIDTH;
            height_q           = RST_SCREEN_HEIGHT;
            strip_q            = RST_STRIP_HEIGHT;
            slop_q             = RST_TAP_SLOP;
            swipe_q            = RST_SWIPE_DIST;
            hold_us_q          = RST_LONG_PRESS;
            gesture_on         = 1'b0;
            hold_done          = 1'b0;
            start_x            = '0;
            start_y            = '0;
            start_time         = '0;
            held_action        = ACT_NONE;
            mismatches         = 0;
            dispatches_checked = 0;
            actions_checked    = 0;
            due_dispatches.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_SCREEN_WIDTH:  width_q   = cfg_wr_data[DIM_W-1:0];
                    REG_SCREEN_HEIGHT: height_q  = cfg_wr_data[DIM_W-1:0];
                    REG_STRIP_HEIGHT:  strip_q   = cfg_wr_data[DIM_W-1:0];
                    REG_TAP_SLOP:      slop_q    = cfg_wr_data[DIM_W-1:0];
                    REG_SWIPE_DIST:    swipe_q   = cfg_wr_data[DIM_W-1:0];
                    REG_LONG_PRESS:    hold_us_q = cfg_wr_data[LP_W-1:0];
                    default: ;
                endcase
            end
            // the dispatch leaving now belongs to an older frame, so push first
            if (s_tvalid && s_tready) begin
                predict_dispatch(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                got.action      = action_t'(m_tdata[3:0]);
                got.press       = m_tdata[4];
                got.release_res = m_tdata[5];
                got.origin_x    = m_tdata[18:6];
                got.origin_y    = m_tdata[31:19];
                if (due_dispatches.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected dispatch: action=%0d press=%0b release=%0b",
                             $time, got.action, got.press, got.release_res,
                             " origin=(%0d,%0d)", got.origin_x, got.origin_y);
                end else begin
                    want = due_dispatches.pop_front();
                    dispatches_checked++;
                    if (want.action != ACT_NONE) begin
                        actions_checked++;
                    end
                    if (got.action != want.action || got.press != want.press ||
                        got.release_res != want.release_res ||
                        got.origin_x != want.origin_x || got.origin_y != want.origin_y) begin
                        mismatches++;
                        $display("%0t dispatch mismatch: expected action=%0d press=%0b",
                                 $time, want.action, want.press,
                                 " release=%0b origin=(%0d,%0d)",
                                 want.release_res, want.origin_x, want.origin_y,
                                 "; actual action=%0d press=%0b release=%0b origin=(%0d,%0d)",
                                 got.action, got.press, got.release_res,
                                 got.origin_x, got.origin_y);
                    end
                end
            end
        end
        dispatches_due = due_dispatches.size();
    end

endmodule

@@ tb/sv/tb_touch_gesture_recognizer_top.sv @@
module tb_touch_gesture_recognizer_top;
    import tgr_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [IDX_W-1:0]     cfg_wr_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    int                   mismatches;
    int                   dispatches_due;
    int                   dispatches_checked;
    int                   actions_checked;

    int                   src_idle_pct = 29;
    int                   dst_idle_pct = 51;
    logic                 hold_off_req = 1'b0;
    int                   frames_sent;
    int                   settings_used;
    logic [TIME_W-1:0]    now_us;

    int                   cur_w;
    int                   cur_h;
    int                   cur_strip;
    int                   cur_slop;
    int                   cur_swipe;
    int                   cur_hold_us;

    touch_gesture_recognizer_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    tgr_dispatch_checker u_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .mismatches         (mismatches),
        .dispatches_due     (dispatches_due),
        .dispatches_checked (dispatches_checked),
        .actions_checked    (actions_checked)
    );

    initial begin
        aclk = 1'b0;
    end

    always #10 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random backpressure, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < 400; n++) begin
                    @(negedge aclk);
                end
            end else begin
                m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
            end
        end
    end

    // returns at the falling edge after the transfer with s_tvalid still high
    task automatic send_frame(input logic down, input int x, input int y,
                              input logic [TIME_W-1:0] t, input logic rdr);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {5'd0, t, COORD_W'(y), COORD_W'(x), down};
        s_tuser  <= rdr;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        frames_sent++;
        now_us = t;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (dispatches_due != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= CFG_W'(value);
        @(negedge aclk);
    endtask

    task automatic apply_config(input int w, input int h, input int b, input int slop,
                                input int swipe, input int hold_us);
        wait_idle();
        cur_w       = w;
        cur_h       = h;
        cur_strip   = b;
        cur_slop    = slop;
        cur_swipe   = swipe;
        cur_hold_us = hold_us;
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_STRIP_HEIGHT, b);
        write_reg(REG_TAP_SLOP, slop);
        write_reg(REG_SWIPE_DIST, swipe);
        write_reg(REG_LONG_PRESS, hold_us);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // offset within reach, now and then one step past it
    function automatic int wobble(input int reach);
        int step;
        step = ($urandom_range(0, 7) == 0) ? reach + 1 : int'($urandom_range(0, reach));
        return ($urandom_range(0, 1) != 0) ? -step : step;
    endfunction

    function automatic int start_coord(input int span, input int mark_a, input int mark_b);
        case ($urandom_range(0, 11))
            0: return mark_a - 1 + int'($urandom_range(0, 1));
            1: return mark_b - 1 + int'($urandom_range(0, 1));
            2: return span - 1 + int'($urandom_range(0, 1));
            3: return int'($urandom_range(0, 1)) - 1;
            4: return int'($signed(COORD_W'($urandom)));
            default: return int'($urandom_range(0, (span > 0) ? span - 1 : 0));
        endcase
    endfunction

    initial begin : stimulus
        int                phase;
        int                phase_end;
        int                next_cfg_at;
        int                cfg_round;
        int                w;
        int                h;
        int                b;
        int                slop;
        int                swipe;
        int                hold_us;
        int                x0;
        int                y0;
        int                dx;
        int                dy;
        int                adx;
        int                ady;
        logic              rdr;
        logic              hold_off_issued;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] stamp;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        aresetn      = 1'b0;
        frames_sent  = 0;
        now_us       = '0;
        cur_w        = int'(RST_SCREEN_WIDTH);
        cur_h        = int'(RST_SCREEN_HEIGHT);
        cur_strip    = int'(RST_STRIP_HEIGHT);
        cur_slop     = int'(RST_TAP_SLOP);
        cur_swipe    = int'(RST_SWIPE_DIST);
        cur_hold_us  = int'(RST_LONG_PRESS);
        settings_used = 1;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames on the reset thresholds
        send_frame(1'b0, 300, 300, 48'd5, 1'b1);            // release with no gesture
        send_frame(1'b1, 0, 0, 48'd10, 1'b0);               // ui item tap at the corner
        send_frame(1'b0, 0, 0, 48'd20, 1'b0);
        send_frame(1'b1, 1071, 1447, 48'd30, 1'b1);         // page forward, far corner
        send_frame(1'b0, 1071, 1447, 48'd40, 1'b1);
        send_frame(1'b1, 0, 1368, 48'd50, 1'b0);            // back, moved by the full slop
        send_frame(1'b0, 20, 1388, 48'd60, 1'b0);
        send_frame(1'b1, 536, 1400, 48'd70, 1'b0);          // confirm, right half of strip
        send_frame(1'b0, 536, 1400, 48'd80, 1'b0);
        send_frame(1'b1, -4096, 4095, 48'd90, 1'b1);        // off screen tap is empty
        send_frame(1'b0, -4096, 4095, 48'd100, 1'b1);
        send_frame(1'b1, 320, 1367, 48'd1000, 1'b1);        // long press, one short then due
        send_frame(1'b1, 330, 1360, 48'd500999, 1'b1);
        send_frame(1'b1, 330, 1360, 48'd501000, 1'b1);
        send_frame(1'b0, 400, 1200, 48'd501100, 1'b1);
        send_frame(1'b1, 500, 500, 48'd3000000, 1'b1);      // time runs backwards
        send_frame(1'b1, 500, 500, 48'd100, 1'b1);
        send_frame(1'b0, 510, 490, 48'd200, 1'b1);
        send_frame(1'b1, 600, 700, 48'd300, 1'b0);          // swipe right
        send_frame(1'b0, 500, 690, 48'd400, 1'b0);
        send_frame(1'b1, 600, 700, 48'd500, 1'b0);          // swipe left
        send_frame(1'b0, 700, 700, 48'd600, 1'b0);
        send_frame(1'b1, 600, 700, 48'd700, 1'b0);          // swipe up, exactly the distance
        send_frame(1'b0, 610, 780, 48'd800, 1'b0);
        send_frame(1'b1, 4095, 700, 48'hFFFF_FFFF_FFFF, 1'b0); // swipe down at top of time
        send_frame(1'b0, 4095, 600, 48'd0, 1'b0);

        next_cfg_at     = frames_sent;
        cfg_round       = 0;
        hold_off_issued = 1'b0;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 29; dst_idle_pct = 51; end
                1: begin src_idle_pct = 51; dst_idle_pct = 29; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            phase_end = 26 + (phase + 1) * 510;
            while (frames_sent < phase_end) begin
                if (frames_sent >= next_cfg_at) begin
                    case (cfg_round)
                        0: apply_config(4095, 4095, 0, 0, 0, 0);
                        1: apply_config(0, 4095, 4095, 4095, 4095, 24'hFFFFFF);
                        2: apply_config(640, 100, 100, 3, 4095, 24'hFFFFFF);
                        default: begin
                            w = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 16))
                                                            : int'($urandom_range(1, 4095));
                            h = $urandom_range(1, 4095);
                            b = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4095))
                                                            : int'($urandom_range(0, h / 4));
                            slop = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4095))
                                                               : int'($urandom_range(0, 40));
                            swipe = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 4095))
                                                                : int'($urandom_range(0, 300));
                            case ($urandom_range(0, 2))
                                0: hold_us = $urandom_range(0, 3000);
                                1: hold_us = 500000;
                                default: hold_us = $urandom_range(0, 24'hFFFFFF);
                            endcase
                            apply_config(w, h, b, slop, swipe, hold_us);
                        end
                    endcase
                    cfg_round++;
                    next_cfg_at = frames_sent + 100;
                end
                // keep offering frames while the result side holds off
                if (!hold_off_issued && frames_sent >= 300) begin
                    hold_off_issued = 1'b1;
                    hold_off_req    = 1'b1;
                end
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_frame(1'($urandom_range(0, 1)), int'($signed(COORD_W'($urandom))),
                                   int'($signed(COORD_W'($urandom))),
                                   TIME_W'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
                    end
                end else begin
                    rdr = 1'($urandom_range(0, 1));
                    x0  = start_coord(cur_w, cur_w * 3 / 10, cur_w * 7 / 10);
                    if ($urandom_range(0, 3) == 0) begin
                        x0 = cur_w / 2 - 1 + int'($urandom_range(0, 1));
                    end
                    y0 = start_coord(cur_h, cur_h - cur_strip, cur_h - cur_strip);
                    t0 = ($urandom_range(0, 19) == 0) ? TIME_W'({$urandom, $urandom})
                                                      : now_us + TIME_W'($urandom_range(0, 5000));
                    send_frame(1'b1, x0, y0, t0, rdr);
                    repeat ($urandom_range(0, 3)) begin
                        case ($urandom_range(0, 7))
                            0, 1: stamp = t0 + TIME_W'($urandom_range(0, cur_hold_us));
                            2: stamp = t0 + TIME_W'(cur_hold_us) - 1;
                            3: stamp = t0 + TIME_W'(cur_hold_us);
                            4, 5: stamp = t0 + TIME_W'(cur_hold_us)
                                          + TIME_W'($urandom_range(1, 100000));
                            6: stamp = t0 - TIME_W'($urandom_range(1, 100000));
                            default: stamp = TIME_W'({$urandom, $urandom});
                        endcase
                        if ($urandom_range(0, 9) == 0) begin
                            rdr = ~rdr;
                        end
                        send_frame(1'b1, x0 + wobble(cur_slop), y0 + wobble(cur_slop),
                                   stamp, rdr);
                    end
                    case ($urandom_range(0, 5))
                        0, 1: begin
                            dx = wobble(cur_slop);
                            dy = wobble(cur_slop);
                        end
                        2: begin
                            adx = cur_swipe + int'($urandom_range(0, 150));
                            ady = (adx > 0) ? int'($urandom_range(0, adx - 1)) : 0;
                            dx  = ($urandom_range(0, 1) != 0) ? -adx : adx;
                            dy  = ($urandom_range(0, 1) != 0) ? -ady : ady;
                        end
                        3: begin
                            ady = cur_swipe + int'($urandom_range(0, 150));
                            adx = $urandom_range(0, ady);
                            dx  = ($urandom_range(0, 1) != 0) ? -adx : adx;
                            dy  = ($urandom_range(0, 1) != 0) ? -ady : ady;
                        end
                        4: begin
                            dx = wobble(cur_swipe);
                            dy = wobble(cur_slop + int'($urandom_range(0, 60)));
                        end
                        default: begin
                            dx = int'($signed(COORD_W'($urandom))) - x0;
                            dy = int'($signed(COORD_W'($urandom))) - y0;
                        end
                    endcase
                    send_frame(1'b0, x0 + dx, y0 + dy,
                               now_us + TIME_W'($urandom_range(0, 1000)), rdr);
                end
            end
        end

        wait_idle();
        $display("Run covered %0d touch frames over %0d threshold settings:", frames_sent,
                 settings_used);
        $display("%0d dispatches checked, %0d of them carrying an action.",
                 dispatches_checked, actions_checked);
        if (mismatches == 0 && dispatches_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
